### hw/rtl/mim_pkg.sv
package mim_pkg;

    localparam int unsigned PixW     = 8;
    localparam int unsigned SqW      = 18;
    localparam int unsigned CntW     = 23;
    localparam int unsigned SumW     = 48;
    localparam int unsigned DvdW     = SumW;
    localparam int unsigned DvsW     = 23;
    localparam int unsigned RootW    = 34;
    localparam int unsigned MeanW    = 32;
    localparam int unsigned MaxFramePixels = 4194304;
    localparam logic [CntW-1:0] CountCap =
        (MaxFramePixels < 32'h7F_FFFF) ? CntW'(MaxFramePixels) : {CntW{1'b1}};

    // The plain colour term s * 2^16 / 3 is split as s * 21845 + s / 3, and s / 3 is
    // taken by a rounded-up reciprocal that is exact for every sum below 2^19.
    localparam logic [31:0] PlainMul   = 32'((64'd1 << 16) / 64'd3);
    localparam int unsigned ThirdShift = 20;
    localparam logic [36:0] ThirdRecip = 37'((64'd1 << ThirdShift) / 64'd3 + 64'd1);

    // The rooted term needs s * 2^32 / 195075. With 2^32 = RootMul * 195075 + RootRem
    // this is s * RootMul plus (s * RootRem) / 195075, and the second quotient is taken
    // by a rounded-up reciprocal that is exact for every dividend below 2^28.
    localparam logic [63:0] RootDen    = 64'd195075;
    localparam logic [32:0] RootMul    = 33'((64'd1 << 32) / RootDen);
    localparam logic [27:0] RootRem    = 28'((64'd1 << 32) % RootDen);
    localparam int unsigned RootShift  = 46;
    localparam logic [56:0] RootRecip  = 57'((64'd1 << RootShift) / RootDen + 64'd1);

    typedef enum logic [1:0] {
        REG_GRAY   = 2'd0,
        REG_ROOTED = 2'd1,
        REG_MASK   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_QUOT,
        ST_SQRT,
        ST_ACC,
        ST_FIN,
        ST_DIV_MEAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    sqrt_start;
        logic    acc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
        logic gray;
        logic rooted;
        logic div_busy;
        logic sqrt_busy;
        logic count_zero;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/mim_div.sv
module mim_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [mim_pkg::DvdW-1:0]       dividend,
    input  logic [mim_pkg::DvsW-1:0]       divisor,
    output logic                           busy,
    output logic [mim_pkg::DvdW-1:0]       quotient
);

    logic [mim_pkg::DvsW:0]   rem_reg, rem_next;
    logic [mim_pkg::DvdW-1:0] quo_reg, quo_next;
    logic [mim_pkg::DvsW-1:0] dvs_reg, dvs_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic [mim_pkg::DvsW:0]   rem_sh;
    logic                     fits;

    always_comb begin
        rem_sh   = {rem_reg[mim_pkg::DvsW-1:0], quo_reg[mim_pkg::DvdW-1]};
        fits     = rem_sh >= {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'(mim_pkg::DvdW);
        end else if (cnt_reg != '0) begin
            rem_next = fits ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_next = {quo_reg[mim_pkg::DvdW-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

### hw/rtl/mim_ctrl.sv
module mim_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mim_pkg::sts_t   sts,
    output mim_pkg::cmd_t   cmd
);

    mim_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mim_pkg::ST_IDLE:     if (in_valid) state_next = mim_pkg::ST_EVAL;
            mim_pkg::ST_EVAL: begin
                if (sts.skip || sts.gray || !sts.rooted) state_next = mim_pkg::ST_ACC;
                else                                     state_next = mim_pkg::ST_QUOT;
            end
            mim_pkg::ST_QUOT:     state_next = mim_pkg::ST_SQRT;
            mim_pkg::ST_SQRT: begin
                if (!sts.sqrt_busy) state_next = mim_pkg::ST_ACC;
            end
            mim_pkg::ST_ACC:      state_next = sts.last ? mim_pkg::ST_FIN : mim_pkg::ST_IDLE;
            mim_pkg::ST_FIN: begin
                state_next = sts.count_zero ? mim_pkg::ST_OUT : mim_pkg::ST_DIV_MEAN;
            end
            mim_pkg::ST_DIV_MEAN: if (!sts.div_busy) state_next = mim_pkg::ST_OUT;
            mim_pkg::ST_OUT:      if (sts.out_free) state_next = mim_pkg::ST_IDLE;
            default:              state_next = mim_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mim_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            mim_pkg::ST_QUOT:     cmd.sqrt_start = 1'b1;
            mim_pkg::ST_ACC:      cmd.acc = 1'b1;
            mim_pkg::ST_FIN:      cmd.div_start = !sts.count_zero;
            mim_pkg::ST_OUT:      cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mim_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/mim_datapath.sv
module mim_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic                          cfg_wdata,
    input  logic [6*mim_pkg::PixW-1:0]    pix,
    input  logic                          last,
    input  logic                          out_ready,
    input  mim_pkg::cmd_t                 cmd,
    output mim_pkg::sts_t                 sts,
    output logic                          out_valid,
    output logic [mim_pkg::MeanW-1:0]     mean_error,
    output logic [mim_pkg::CntW-1:0]      used_pixels,
    output logic [mim_pkg::CntW-1:0]      skipped_pixels,
    output logic                          no_valid_pixels
);

    logic gray_reg, rooted_reg, mask_reg;
    logic skip_reg, last_reg;
    logic [mim_pkg::SqW-1:0]   s_reg;
    logic [15:0]               g_reg;
    logic [31:0]               plain_reg;
    logic [32:0]               base_reg;
    logic [27:0]               t_reg;
    logic [mim_pkg::SumW-1:0]  sum_reg, sum_next;
    logic [mim_pkg::CntW-1:0]  cnt_reg, cnt_next, skc_reg, skc_next;
    logic                      out_valid_reg;
    logic [mim_pkg::MeanW-1:0] mean_reg;
    logic [mim_pkg::CntW-1:0]  used_reg, skipped_reg;
    logic                      none_reg;

    logic [mim_pkg::RootW-1:0] x_reg, r_reg, bit_reg;
    logic [mim_pkg::RootW-1:0] r_plus;

    logic [7:0] a0, a1, a2, b0, b1, b2, d0, d1, d2;
    logic [mim_pkg::SqW-1:0] s_new;
    logic skip_new;
    logic [36:0] third_prod;
    logic [56:0] recip_prod;
    logic [32:0] root_q;
    logic [mim_pkg::DvdW-1:0] quo;
    logic div_busy;
    logic [mim_pkg::SumW-1:0] term;
    logic [mim_pkg::SumW:0]   sum_add;

    always_comb begin
        {b2, b1, b0, a2, a1, a0} = pix;
        d0 = (a0 > b0) ? a0 - b0 : b0 - a0;
        d1 = (a1 > b1) ? a1 - b1 : b1 - a1;
        d2 = (a2 > b2) ? a2 - b2 : b2 - a2;
        s_new = mim_pkg::SqW'(d0 * d0) + mim_pkg::SqW'(d1 * d1) + mim_pkg::SqW'(d2 * d2);
        if (gray_reg) begin
            skip_new = mask_reg && (a0 == 8'hFF || a0 == 8'h00);
        end else begin
            skip_new = mask_reg && ((a0 == 8'hFF && a1 == 8'hFF && a2 == 8'hFF) ||
                                    (b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00));
        end
    end

    // Constant divisions of the colour terms by reciprocal multiplication.
    always_comb begin
        third_prod = {19'd0, s_reg} * mim_pkg::ThirdRecip;
        recip_prod = {29'd0, t_reg} * mim_pkg::RootRecip;
        root_q     = base_reg + {22'd0, recip_prod[56:mim_pkg::RootShift]};
    end

    mim_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign r_plus = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else if (cmd.sqrt_start) begin
            bit_reg <= mim_pkg::RootW'(64'h1_0000_0000);
        end else if (bit_reg != '0) begin
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.sqrt_start) begin
            x_reg <= {1'b0, root_q};
            r_reg <= '0;
        end else if (bit_reg != '0) begin
            if (x_reg >= r_plus) begin
                x_reg <= x_reg - r_plus;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    always_comb begin
        if (skip_reg) begin
            term = '0;
        end else if (gray_reg) begin
            term = mim_pkg::SumW'({g_reg, 16'd0});
        end else if (rooted_reg) begin
            term = mim_pkg::SumW'(r_reg);
        end else begin
            term = mim_pkg::SumW'(plain_reg);
        end
        sum_add  = {1'b0, sum_reg} + {1'b0, term};
        sum_next = sum_add[mim_pkg::SumW] ? {mim_pkg::SumW{1'b1}} : sum_add[mim_pkg::SumW-1:0];
        cnt_next = (!skip_reg && cnt_reg < mim_pkg::CountCap) ? cnt_reg + 1'b1 : cnt_reg;
        skc_next = (skip_reg && skc_reg < mim_pkg::CountCap) ? skc_reg + 1'b1 : skc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_reg      <= 1'b1;
            rooted_reg    <= 1'b0;
            mask_reg      <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            skc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mim_pkg::REG_GRAY:   gray_reg   <= cfg_wdata;
                    mim_pkg::REG_ROOTED: rooted_reg <= cfg_wdata;
                    mim_pkg::REG_MASK:   mask_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.acc) begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                skc_reg <= skc_next;
            end else if (cmd.out_load) begin
                sum_reg <= '0;
                cnt_reg <= '0;
                skc_reg <= '0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            s_reg    <= s_new;
            g_reg    <= d0 * d0;
            skip_reg <= skip_new;
            last_reg <= last;
        end
        // The colour products are registered from the held sum and are ready in the cycle after it.
        plain_reg <= {14'd0, s_reg} * mim_pkg::PlainMul
                     + {15'd0, third_prod[36:mim_pkg::ThirdShift]};
        base_reg  <= {15'd0, s_reg} * mim_pkg::RootMul;
        t_reg     <= {10'd0, s_reg} * mim_pkg::RootRem;
        if (cmd.out_load) begin
            none_reg    <= cnt_reg == '0;
            used_reg    <= cnt_reg;
            skipped_reg <= skc_reg;
            if (cnt_reg == '0) begin
                mean_reg <= '0;
            end else if (quo[mim_pkg::DvdW-1:mim_pkg::MeanW] != '0) begin
                mean_reg <= {mim_pkg::MeanW{1'b1}};
            end else begin
                mean_reg <= quo[mim_pkg::MeanW-1:0];
            end
        end
    end

    always_comb begin
        sts.skip       = skip_reg;
        sts.last       = last_reg;
        sts.gray       = gray_reg;
        sts.rooted     = rooted_reg;
        sts.div_busy   = div_busy;
        sts.sqrt_busy  = bit_reg != '0;
        sts.count_zero = cnt_reg == '0;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign mean_error      = mean_reg;
    assign used_pixels     = used_reg;
    assign skipped_pixels  = skipped_reg;
    assign no_valid_pixels = none_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy) else $error("divider started while busy");
    a_sqrt_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sqrt_start |=> bit_reg != '0) else $error("root unit did not start");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || out_ready)) else $error("result overwritten");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> cnt_reg == '0 && skc_reg == '0) else $error("frame not cleared");

endmodule

### hw/rtl/masked_image_mse.sv
// Channel   Direction  Handshake               Payload
// input     in         s_tvalid / s_tready     s_tdata (A0..B2), s_tlast (frame end)
// result    out        m_tvalid / m_tready     m_tdata (mean, used, skipped), m_tuser
// config    in         cfg_wr_en               cfg_index, cfg_wdata
//
// A pixel passes through load, evaluation and accumulation in grey mode, when masked and
// for the plain colour term; the rooted term adds the reciprocal products and the 17-step
// root unit. The last pixel of a frame adds the 48-step mean division, which is skipped
// when every pixel of the frame was masked.
// Reset is synchronous and active low; it restores the register defaults and empties
// the sums. A waiting result sits in an output register, so the next frame's pixels
// are taken while m_tready is low; only a second finished frame waits for it.
module masked_image_mse (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_ch0, a_ch1, a_ch2, b_ch0, b_ch1, b_ch2 from the lowest bit up.
    input  logic [47:0] s_tdata,
    // frame_end: the transfer carries the last pixel of the frame.
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mean_error, used_pixels, skipped_pixels from the lowest bit up, two zero bits on top.
    output logic [79:0] m_tdata,
    // no_valid_pixels.
    output logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_wdata
);

    mim_pkg::cmd_t cmd;
    mim_pkg::sts_t sts;
    logic [31:0] mean;
    logic [22:0] used, skipped;

    // The controller sequences each pixel through the shared arithmetic units.
    mim_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the sums, the divider, the root unit and the result.
    mim_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .pix             (s_tdata),
        .last            (s_tlast),
        .out_ready       (m_tready),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (m_tvalid),
        .mean_error      (mean),
        .used_pixels     (used),
        .skipped_pixels  (skipped),
        .no_valid_pixels (m_tuser)
    );

    // Pack the result fields for the output transfer.
    assign m_tdata = {2'b00, skipped, used, mean};

endmodule

### tb/sv/tb_masked_image_mse.sv
`timescale 1ns / 100ps

module tb_masked_image_mse;

    // One pixel pair as it travels on the input channel.
    typedef struct {
        logic [7:0] a [3];
        logic [7:0] b [3];
        logic       frame_end;
    } pixel_t;

    // One frame result as it leaves the block.
    typedef struct {
        logic [31:0] mean_error;
        logic [22:0] used_pixels;
        logic [22:0] skipped_pixels;
        logic        no_valid_pixels;
    } frame_result_t;

    // The scoreboard keeps its own copy of the mode bits and the frame sums, works out
    // each frame's result when the frame-end transfer is accepted, and checks results
    // in order against that queue.
    class mse_scoreboard;
        logic          gray, rooted, mask_on;
        logic [47:0]   err_sum;
        logic [22:0]   used_cnt, skip_cnt;
        frame_result_t pending_frames[$];
        int            mismatches;

        function new();
            gray = 1'b1;
            rooted = 1'b0;
            mask_on = 1'b0;
            err_sum = '0;
            used_cnt = '0;
            skip_cnt = '0;
            mismatches = 0;
        endfunction

        function void write_reg(mim_pkg::reg_index_t idx, logic val);
            case (idx)
                mim_pkg::REG_GRAY:   gray = val;
                mim_pkg::REG_ROOTED: rooted = val;
                mim_pkg::REG_MASK:   mask_on = val;
                default: ;
            endcase
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r, bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= r + bitv) begin
                    x = x - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv >>= 2;
            end
            return r;
        endfunction

        function void note_pixel(pixel_t p);
            logic          skip;
            logic [63:0]   term, s, d;
            logic [22:0]   cap;
            logic [63:0]   mean;
            frame_result_t r;
            skip = 1'b0;
            term = 0;
            cap = mim_pkg::CountCap;
            if (gray) begin
                if (mask_on && (p.a[0] == 8'd255 || p.a[0] == 8'd0)) begin
                    skip = 1'b1;
                end else begin
                    d = (p.a[0] > p.b[0]) ? p.a[0] - p.b[0] : p.b[0] - p.a[0];
                    term = (d * d) << 16;
                end
            end else begin
                if (mask_on && ((p.a[0] == 8'd255 && p.a[1] == 8'd255 && p.a[2] == 8'd255)
                        || (p.b[0] == 8'd0 && p.b[1] == 8'd0 && p.b[2] == 8'd0))) begin
                    skip = 1'b1;
                end else begin
                    s = 0;
                    for (int i = 0; i < 3; i++) begin
                        d = (p.a[i] > p.b[i]) ? p.a[i] - p.b[i] : p.b[i] - p.a[i];
                        s += d * d;
                    end
                    if (rooted) term = int_sqrt((s << 32) / 64'd195075);
                    else term = (s << 16) / 64'd3;
                end
            end
            if (skip) begin
                if (skip_cnt < cap) skip_cnt++;
            end else begin
                if (64'hFFFF_FFFF_FFFF - err_sum < term) err_sum = 48'hFFFF_FFFF_FFFF;
                else err_sum = err_sum + term[47:0];
                if (used_cnt < cap) used_cnt++;
            end
            if (p.frame_end) begin
                mean = 0;
                if (used_cnt != 0) begin
                    mean = {16'd0, err_sum} / used_cnt;
                    if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
                end
                r.mean_error = mean[31:0];
                r.used_pixels = used_cnt;
                r.skipped_pixels = skip_cnt;
                r.no_valid_pixels = (used_cnt == 0);
                pending_frames.push_back(r);
                err_sum = '0;
                used_cnt = '0;
                skip_cnt = '0;
            end
        endfunction

        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result mean=%h used=%0d", got.mean_error,
                             got.used_pixels);
                return;
            end
            want = pending_frames.pop_front();
            if (got.mean_error !== want.mean_error || got.used_pixels !== want.used_pixels
                    || got.skipped_pixels !== want.skipped_pixels
                    || got.no_valid_pixels !== want.no_valid_pixels) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: mean %h/%h used %0d/%0d skipped %0d/%0d none %b/%b",
                             want.mean_error, got.mean_error, want.used_pixels,
                             got.used_pixels, want.skipped_pixels, got.skipped_pixels,
                             want.no_valid_pixels, got.no_valid_pixels);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic        cfg_wdata;

    masked_image_mse dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mse_scoreboard frame_board;
    int unsigned   idle_cycles;
    // While set, neither side inserts random idle cycles.
    logic          steady;
    // A long mean division on the last pixel sets the settle time before a register write.
    localparam int unsigned SettleCycles = 200;
    localparam int unsigned WatchdogLimit = 20000;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // The result side: every accepted transfer goes straight to the scoreboard, and the
    // ready line drops now and then unless the steady stretch is running.
    always @(posedge aclk) begin
        frame_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.mean_error = m_tdata[31:0];
                got.used_pixels = m_tdata[54:32];
                got.skipped_pixels = m_tdata[77:55];
                got.no_valid_pixels = m_tuser;
                frame_board.check_result(got);
            end
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    // Drives one register write and waits for the clock edge that takes it; the caller lowers
    // the write enable after its last write, so back-to-back writes keep it high.
    task automatic write_reg(mim_pkg::reg_index_t idx, logic val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        frame_board.write_reg(idx, val);
    endtask

    // Stops offering pixels, waits for every outstanding result, then gives the block
    // time to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_board.pending_frames.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic set_modes(logic g, logic r, logic m);
        drain();
        write_reg(mim_pkg::REG_GRAY, g);
        write_reg(mim_pkg::REG_ROOTED, r);
        write_reg(mim_pkg::REG_MASK, m);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one pixel pair and holds it until the block takes it. Valid stays high
    // between back-to-back pixels, so it is never lowered and raised in the same step.
    task automatic send_pixel(pixel_t p);
        while (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.b[2], p.b[1], p.b[0], p.a[2], p.a[1], p.a[0]};
        s_tlast <= p.frame_end;
        do @(posedge aclk); while (!s_tready);
        frame_board.note_pixel(p);
    endtask

    function automatic logic [7:0] rand_byte();
        // Extremes turn up often so that the masks and the largest terms are hit.
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t make_pixel(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                          logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                          logic last);
        pixel_t p;
        p.a[0] = a0; p.a[1] = a1; p.a[2] = a2;
        p.b[0] = b0; p.b[1] = b1; p.b[2] = b2;
        p.frame_end = last;
        return p;
    endfunction

    // A frame of random pixels; now and then a pixel is fully saturated or fully blank
    // so that the colour mask fires.
    task automatic send_frame(int unsigned len);
        pixel_t p;
        for (int unsigned i = 0; i < len; i++) begin
            p = make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                           rand_byte(), i == len - 1);
            case ($urandom_range(7))
                0: p.a = '{8'd255, 8'd255, 8'd255};
                1: p.b = '{8'd0, 8'd0, 8'd0};
                default: ;
            endcase
            send_pixel(p);
        end
    endtask

    initial begin
        int unsigned sent;
        frame_board = new();
        idle_cycles = 0;
        steady = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = mim_pkg::REG_GRAY;
        cfg_wdata = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the reset modes: grey, plain, mask off.
        send_pixel(make_pixel(8'd255, 8'd1, 8'd2, 8'd0, 8'd3, 8'd4, 1'b1));
        set_modes(1'b1, 1'b1, 1'b1);
        // Grey mask on both ends of channel 0, then a frame with every pixel masked.
        send_pixel(make_pixel(8'd0, 8'd9, 8'd9, 8'd200, 8'd9, 8'd9, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd254, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(make_pixel(8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1));
        set_modes(1'b0, 1'b0, 1'b1);
        // Colour mask: A saturated, B blank, and near misses of both.
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 1'b0));
        send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd1, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
        set_modes(1'b0, 1'b1, 1'b0);
        // Rooted term at its largest distance, at zero, and in between.
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(make_pixel(8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 1'b1));
        send_pixel(make_pixel(8'd0, 8'd128, 8'd255, 8'd255, 8'd127, 8'd0, 1'b0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1));
        set_modes(1'b0, 1'b0, 1'b0);
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd0, 1'b1));

        // Random part: short frames in random combinations of modes, with a long steady stretch
        // in the middle and a pause until all results are in when a round nears 500 to 560 pixels.
        sent = 0;
        while (sent < 800) begin
            set_modes(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (int f = 0; f < 4; f++) begin
                int unsigned len;
                len = $urandom_range(1, 12);
                steady = (sent >= 300 && sent < 450);
                send_frame(len);
                sent += len;
                if (f == 1 && sent > 500 && sent < 560) drain();
            end
        end
        steady = 1'b0;

        drain();
        if (frame_board.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mim_pkg.sv
hw/rtl/mim_div.sv
hw/rtl/mim_ctrl.sv
hw/rtl/mim_datapath.sv
hw/rtl/masked_image_mse.sv
tb/sv/tb_masked_image_mse.sv
